[sv/srp_pkg.sv]
// Shared types and constants for the sized RAM port with console output.
// Used by the top level and the port checker; depends on nothing else.
package srp_pkg;

  // Access kinds.
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Access sizes (code three is handled as a word).
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_RAM_BASE     = 1'b0;
  localparam logic CFG_CONSOLE_ADDR = 1'b1;

  // Request transaction payload.
  typedef struct packed {
    logic        mode;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_t;

  // Response transaction payload.
  typedef struct packed {
    logic signed [31:0] read_data;
    logic               fault;
    logic               char_valid;
    logic [7:0]         char_out;
  } out_t;

endpackage

[sv/srp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write to the same entry in one cycle return the old data.
module srp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/sized_ram_port_with_console_write.sv]
// A transaction waits in the access stage while its RAM word is read; then its
// response is registered. One transaction per cycle unless the output stalls; the
// RAM read is issued at acceptance and sub-word writes merge into the returned
// word and write back as the access stage advances. Back-to-back accesses to the
// same word use a one-entry forward path. Reset clears the configuration and
// valid bits and the forward hit flag only; RAM stays undefined until written.
module sized_ram_port_with_console_write #(
  parameter int RAM_BYTES = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  srp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output srp_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_wdata
);

  import srp_pkg::*;

  localparam int          RamWords  = (RAM_BYTES + 3) / 4;
  localparam int          AddrW     = $clog2(RamWords);
  localparam logic [31:0] RamBytesW = 32'(RAM_BYTES);

  // Configuration registers.
  logic [31:0] ram_base_r;
  logic [31:0] console_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r     <= '0;
      console_addr_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RAM_BASE:     ram_base_r     <= cfg_wdata;
        CFG_CONSOLE_ADDR: console_addr_r <= cfg_wdata;
        default:          ram_base_r     <= ram_base_r;
      endcase
    end
  end

  // Request decode: console match, offset and range check.
  logic             in_fire;
  logic [31:0]      in_off;
  logic             in_console;
  logic             in_fault;
  logic [AddrW-1:0] in_widx;

  assign in_fire    = in_valid && in_ready;
  assign in_off     = in_data.address - ram_base_r;
  assign in_console = (in_data.mode == MODE_WRITE) && (in_data.address == console_addr_r);
  assign in_fault   = !in_console && (in_off >= RamBytesW);
  assign in_widx    = in_off[AddrW+1:2];

  // Access stage: holds the transaction while its RAM word is read.
  logic             s1_valid_r;
  logic             s1_mode_r;
  logic [1:0]       s1_size_r;
  logic [1:0]       s1_lo_r;
  logic [AddrW-1:0] s1_widx_r;
  logic [31:0]      s1_wdata_r;
  logic             s1_console_r;
  logic             s1_fault_r;
  logic             s1_adv;

  logic             out_valid_r;
  out_t             out_data_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r    <= in_data.mode;
      s1_size_r    <= in_data.access_size;
      s1_lo_r      <= in_off[1:0];
      s1_widx_r    <= in_widx;
      s1_wdata_r   <= in_data.write_data;
      s1_console_r <= in_console;
      s1_fault_r   <= in_fault;
    end
  end

  // RAM write-back and read request.
  logic        ram_we;
  logic [31:0] ram_rdata;
  logic [31:0] merged;

  assign ram_we = s1_adv && (s1_mode_r == MODE_WRITE) && !s1_console_r && !s1_fault_r;

  srp_ram #(
    .WIDTH (32),
    .DEPTH (RamWords)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_widx_r),
    .wr_data (merged),
    .rd_en   (in_fire),
    .rd_addr (in_widx),
    .rd_data (ram_rdata)
  );

  // Forward path: a write to the word being read in the same cycle.
  logic        fwd_hit_r;
  logic [31:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_r <= ram_we && (s1_widx_r == in_widx);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= merged;
    end
  end

  // Lane selection, write merge and sign-extended read.
  logic [31:0] word;
  logic [3:0]  lane_en;
  logic [31:0] wrep;
  logic [7:0]  rd_byte;
  logic [15:0] rd_half;
  logic [31:0] rd_ext;

  assign word = fwd_hit_r ? fwd_data_r : ram_rdata;

  always_comb begin
    case (s1_size_r)
      SIZE_BYTE: begin
        lane_en = 4'b0001 << s1_lo_r;
        wrep    = {4{s1_wdata_r[7:0]}};
      end
      SIZE_HALF: begin
        lane_en = s1_lo_r[1] ? 4'b1100 : 4'b0011;
        wrep    = {2{s1_wdata_r[15:0]}};
      end
      default: begin
        lane_en = 4'b1111;
        wrep    = s1_wdata_r;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      merged[8*i +: 8] = lane_en[i] ? wrep[8*i +: 8] : word[8*i +: 8];
    end
  end

  assign rd_byte = word[8*s1_lo_r +: 8];
  assign rd_half = s1_lo_r[1] ? word[31:16] : word[15:0];

  always_comb begin
    case (s1_size_r)
      SIZE_BYTE: rd_ext = {{24{rd_byte[7]}}, rd_byte};
      SIZE_HALF: rd_ext = {{16{rd_half[15]}}, rd_half};
      default:   rd_ext = word;
    endcase
  end

  // Output register.
  out_t resp;

  always_comb begin
    resp.read_data  = (s1_mode_r == MODE_READ && !s1_fault_r) ? rd_ext : '0;
    resp.fault      = s1_fault_r;
    resp.char_valid = s1_console_r;
    resp.char_out   = s1_console_r ? s1_wdata_r[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/srp_checker.sv]
// Port-level checker for the sized RAM port, bound to the top level.
// Depends on srp_pkg for the response transaction type.
module srp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input srp_pkg::out_t out_data
);

  // A request transaction that is not yet accepted stays asserted.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("request dropped before acceptance");

  // A stalled response transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // A console transaction never reports a fault.
  a_char_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.fault && out_data.char_valid))
    else $error("fault and console character together");

  // Faulting or console transactions return zero read data.
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fault || out_data.char_valid) |-> out_data.read_data == 0)
    else $error("nonzero read data on fault or console write");

  // Without a console character the character byte is zero.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_valid |-> out_data.char_out == 8'd0)
    else $error("character byte set without console write");

endmodule

bind sized_ram_port_with_console_write srp_checker u_srp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/tb_sized_ram_port_with_console_write.sv]
// Self-checking testbench for the sized RAM port with console output.
// Drives random and directed memory accesses and checks every response
// against an in-bench model; depends on srp_pkg and the port RTL only.
`timescale 1ns / 1ps

module tb_sized_ram_port_with_console_write;
  import srp_pkg::*;

  localparam int RAM_SIZE = 65536;
  localparam logic [1:0] SIZE_WORD_ALT = 2'd3;
  localparam int RANDOM_PER_SETTING = 285;

  typedef enum int { RX_OPEN, RX_COIN, RX_EVERY4, RX_CHOKED } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_RAM_BASE;
  logic [31:0] cfg_wdata = '0;

  // Accesses waiting to be driven, and responses the model expects next.
  in_t  access_q[$];
  out_t reply_q[$];

  // Model state: configuration copies, RAM image, and which bytes hold data.
  logic [31:0] base_reg = '0;
  logic [31:0] console_reg = '0;
  logic [31:0] ram_image [RAM_SIZE/4];
  bit          byte_written [RAM_SIZE];
  int unsigned hot_win [3];

  int       bad_replies = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;

  sized_ram_port_with_console_write #(
    .RAM_BYTES(RAM_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Computes the response of one access and applies its effect on the RAM image.
  function automatic out_t emulate_access(in_t req);
    out_t        rsp;
    logic [1:0]  sz;
    logic [31:0] off;
    logic [31:0] word;
    logic [31:0] lanes;
    logic [31:0] raw;
    int unsigned shift;
    rsp = '0;
    sz = (req.access_size == SIZE_WORD_ALT) ? SIZE_WORD : req.access_size;
    if (req.mode == MODE_WRITE && req.address == console_reg) begin
      rsp.char_valid = 1'b1;
      rsp.char_out = req.write_data[7:0];
    end else begin
      off = req.address - base_reg;
      if (off >= RAM_SIZE) begin
        rsp.fault = 1'b1;
      end else begin
        word = ram_image[off >> 2];
        case (sz)
          SIZE_BYTE: begin
            shift = {off[1:0], 3'b000};
            lanes = 32'h0000_00FF << shift;
          end
          SIZE_HALF: begin
            shift = {off[1], 4'b0000};
            lanes = 32'h0000_FFFF << shift;
          end
          default: begin
            shift = 0;
            lanes = 32'hFFFF_FFFF;
          end
        endcase
        if (req.mode == MODE_WRITE) begin
          ram_image[off >> 2] = (word & ~lanes) | ((req.write_data << shift) & lanes);
        end else begin
          raw = (word & lanes) >> shift;
          case (sz)
            SIZE_BYTE: rsp.read_data = {{24{raw[7]}}, raw[7:0]};
            SIZE_HALF: rsp.read_data = {{16{raw[15]}}, raw[15:0]};
            default:   rsp.read_data = raw;
          endcase
        end
      end
    end
    return rsp;
  endfunction

  // Queues one access. A read of bytes that were never written is turned
  // into a write of the same place, so stored data is always defined.
  function automatic void plan_access(logic mode, logic [1:0] size, logic [31:0] addr,
                                      logic [31:0] data);
    in_t         req;
    logic [31:0] off;
    int unsigned first;
    int unsigned span;
    bit          all_set;
    req.mode = mode;
    req.access_size = size;
    req.address = addr;
    req.write_data = data;
    off = addr - base_reg;
    if (!(mode == MODE_WRITE && addr == console_reg) && off < RAM_SIZE) begin
      case (size)
        SIZE_BYTE: begin
          first = off;
          span = 1;
        end
        SIZE_HALF: begin
          first = {off[31:1], 1'b0};
          span = 2;
        end
        default: begin
          first = {off[31:2], 2'b00};
          span = 4;
        end
      endcase
      all_set = 1'b1;
      for (int i = 0; i < span; i++) all_set &= byte_written[first + i];
      if (mode == MODE_READ && !all_set) req.mode = MODE_WRITE;
      // A converted read at the console address becomes a console write.
      if (req.mode == MODE_WRITE && addr != console_reg) begin
        for (int i = 0; i < span; i++) byte_written[first + i] = 1'b1;
      end
    end
    access_q.push_back(req);
  endfunction

  // Picks a random access, often inside small windows so reads find data.
  function automatic void random_access();
    logic [31:0] addr;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      addr = base_reg + hot_win[$urandom_range(0, 2)] + $urandom_range(0, 63);
    end else if (pick < 60) begin
      addr = base_reg + $urandom_range(0, RAM_SIZE - 1);
    end else if (pick < 70) begin
      addr = base_reg + RAM_SIZE + $urandom_range(0, 7);
    end else if (pick < 75) begin
      addr = base_reg - $urandom_range(1, 8);
    end else if (pick < 88) begin
      addr = $urandom;
    end else begin
      addr = console_reg + $urandom_range(0, 2) - 1;
    end
    plan_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), addr, $urandom);
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_RAM_BASE) base_reg = val;
    else console_reg = val;
  endtask

  // Waits until every queued access is accepted and every response is back.
  task automatic drain();
    while (access_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    bad_replies++;
    if (bad_replies <= 10) begin
      $display("%s: expected rd=%h fault=%b char=%b/%h, got rd=%h fault=%b char=%b/%h",
               what, want.read_data, want.fault, want.char_valid, want.char_out,
               got.read_data, got.fault, got.char_valid, got.char_out);
    end
  endtask

  // Request driver: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) reply_q.push_back(emulate_access(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || access_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data <= access_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Response monitor: checks each transaction and stalls in changing patterns.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected response", '0, out_data);
        end else begin
          out_t want;
          want = reply_q.pop_front();
          if (out_data.read_data !== want.read_data || out_data.fault !== want.fault ||
              out_data.char_valid !== want.char_valid || out_data.char_out !== want.char_out)
            report_mismatch("response mismatch", want, out_data);
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(32, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_EVERY4: out_ready <= (rx_mode_left % 4) != 0;
        default:   out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    logic [31:0] b;
    logic [31:0] settings [6][2];
    settings = '{'{32'h8000_0000, 32'h1000_0000}, '{32'hFFFF_8000, 32'hFFFF_8010},
                 '{32'h0000_0000, 32'h0000_0000}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
                 '{$urandom, $urandom}, '{32'h0000_0000, 32'hFFFF_FFFF}};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: console sits inside RAM, eight bytes above the base.
    b = 32'h0001_0000;
    write_reg(CFG_RAM_BASE, b);
    write_reg(CFG_CONSOLE_ADDR, b + 8);
    plan_access(MODE_WRITE, SIZE_WORD, b, 32'h80FF_7F01);
    plan_access(MODE_READ, SIZE_BYTE, b, '0);
    plan_access(MODE_READ, SIZE_BYTE, b + 1, '0);
    plan_access(MODE_READ, SIZE_BYTE, b + 2, '0);
    plan_access(MODE_READ, SIZE_BYTE, b + 3, '0);
    plan_access(MODE_READ, SIZE_HALF, b, '0);
    plan_access(MODE_READ, SIZE_HALF, b + 3, '0);
    plan_access(MODE_READ, SIZE_WORD, b + 2, '0);
    plan_access(MODE_READ, SIZE_WORD_ALT, b + 1, '0);
    plan_access(MODE_WRITE, SIZE_BYTE, b + 1, 32'hAAAA_AA80);
    plan_access(MODE_WRITE, SIZE_HALF, b + 2, 32'h1234_FFFF);
    plan_access(MODE_READ, SIZE_WORD, b, '0);
    // Console writes of every size, then a word write that lands on the
    // console word without hitting the console address itself.
    plan_access(MODE_WRITE, SIZE_BYTE, b + 8, 32'h0000_0041);
    plan_access(MODE_WRITE, SIZE_HALF, b + 8, 32'h0000_0142);
    plan_access(MODE_WRITE, SIZE_WORD_ALT, b + 8, 32'hDEAD_BE7E);
    plan_access(MODE_WRITE, SIZE_WORD, b + 9, 32'hCAFE_F00D);
    plan_access(MODE_READ, SIZE_WORD, b + 8, '0);
    // Top of RAM, then faults just past it, below the base and at the extremes.
    plan_access(MODE_WRITE, SIZE_WORD, b + RAM_SIZE - 4, 32'h7FFF_8001);
    plan_access(MODE_READ, SIZE_BYTE, b + RAM_SIZE - 1, '0);
    plan_access(MODE_READ, SIZE_HALF, b + RAM_SIZE - 1, '0);
    plan_access(MODE_READ, SIZE_WORD, b + RAM_SIZE, '0);
    plan_access(MODE_WRITE, SIZE_BYTE, b + RAM_SIZE, 32'hFFFF_FFFF);
    plan_access(MODE_READ, SIZE_BYTE, b - 1, '0);
    plan_access(MODE_READ, SIZE_HALF, 32'h0000_0000, '0);
    plan_access(MODE_WRITE, SIZE_WORD, 32'hFFFF_FFFF, 32'h5555_AAAA);
    drain();

    // Random part, one stretch per register setting.
    foreach (settings[s]) begin
      write_reg(CFG_RAM_BASE, settings[s][0]);
      write_reg(CFG_CONSOLE_ADDR, settings[s][1]);
      hot_win[0] = 0;
      hot_win[1] = RAM_SIZE - 64;
      hot_win[2] = $urandom_range(0, RAM_SIZE / 64 - 1) * 64;
      for (int n = 0; n < RANDOM_PER_SETTING; n++) random_access();
      drain();
    end

    if (bad_replies == 0 && reply_q.size() == 0) begin
      $display("tb_sized_ram_port_with_console_write OK");
    end else begin
      $display("tb_sized_ram_port_with_console_write NOT OK");
    end
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin
    #5_000_000;
    $display("tb_sized_ram_port_with_console_write NOT OK");
    $finish;
  end

endmodule

[sim.f]
sv/srp_pkg.sv
sv/srp_ram.sv
sv/sized_ram_port_with_console_write.sv
sv/srp_checker.sv
tb/tb_sized_ram_port_with_console_write.sv
